[rtl/fan_drive_controller_macros.svh]
// Assertion macros shared by the fan drive controller modules
`ifndef FAN_DRIVE_CONTROLLER_MACROS_SVH
`define FAN_DRIVE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fan drive controller: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define FDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fan drive controller: next-cycle check failed");

`endif

[rtl/fdc_pkg.sv]
// Shared constants and controller/datapath interface types for the fan drive controller
package fdc_pkg;

    localparam int TEMP_W    = 16;
    localparam int DRIVE_W   = 8;
    localparam int NUM_W     = TEMP_W + DRIVE_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [DRIVE_W-1:0]  DRIVE_FULL  = 8'd255;
    localparam logic signed [9:0]   STEP_LIMIT  = 10'sd20;
    localparam logic signed [17:0]  DEAD_BAND   = 18'sd4;
    localparam logic signed [16:0]  REF_RESET   = -17'sd80;
    localparam logic [TEMP_W-1:0]   HOT_RESET   = 16'd50;
    localparam logic [TEMP_W-1:0]   COLD_RESET  = 16'd200;
    localparam logic [DRIVE_W-1:0]  BASE_RESET  = 8'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DRIVE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic mul;       // form the ramp numerator and denominator
        logic div_step;  // one restoring division step
        logic commit;    // update state and present the result beat
    } t_fdc_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ramp;      // sample is outside the dead band and on the ramp
        logic out_free;  // output register can take a new beat
    } t_fdc_sts;

endpackage

[rtl/fdc_ctrl.sv]
// Sequencing state machine of the fan drive controller
`include "fan_drive_controller_macros.svh"

module fdc_ctrl import fdc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_fdc_sts i_sts,
    output t_fdc_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // Take an input beat only while idle
    assign o_stall = (r_state != ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = i_sts.ramp ? ST_MUL : ST_FIN;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `FDC_ASSERT_SAME(a_cnt_range, r_state == ST_DIV, r_cnt < CNT_W'(DIV_STEPS))
    `FDC_ASSERT_NEXT(a_load_evals, o_cmd.load, r_state == ST_EVAL)
    `FDC_ASSERT_SAME(a_commit_free, o_cmd.commit, i_sts.out_free)
    `FDC_ASSERT_NEXT(a_mul_divides, o_cmd.mul, r_state == ST_DIV && r_cnt == '0)

endmodule

[rtl/fdc_datapath.sv]
// Registers, ramp arithmetic, serial divider and output register of the fan drive controller
`include "fan_drive_controller_macros.svh"

module fdc_datapath import fdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_fdc_cmd             i_cmd,
    output t_fdc_sts             o_sts,
    input  logic [TEMP_W-1:0]    i_temp_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TEMP_W-1:0]    i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DRIVE_W-1:0]   o_drive,
    output logic                 o_drive_changed
);

    logic [TEMP_W-1:0]        r_hot, r_cold;
    logic [DRIVE_W-1:0]       r_base;
    logic signed [16:0]       r_ref;
    logic [DRIVE_W-1:0]       r_cmd, r_written;
    logic [TEMP_W-1:0]        r_var, r_den, r_rem;
    logic [NUM_W-1:0]         r_quo;
    logic                     r_out_valid;
    logic [DRIVE_W-1:0]       r_out_drive;
    logic                     r_out_changed;

    logic signed [17:0]       w_diff;
    logic                     w_act, w_below_cold, w_below_hot, w_ramp;
    logic [TEMP_W-1:0]        w_span;
    logic [DRIVE_W-1:0]       w_gain;
    logic [NUM_W-1:0]         w_num;
    logic [TEMP_W+1:0]        w_trial;
    logic signed [9:0]        w_target, w_cmd_eff, w_step, w_next;
    logic                     w_up, w_dn, w_ref_upd;
    logic [DRIVE_W-1:0]       w_clamped;
    logic                     w_out_free;

    // Classify the sample against the reference and the limits
    assign w_diff       = $signed({2'b00, r_var}) - $signed({r_ref[16], r_ref});
    assign w_act        = (w_diff > DEAD_BAND) || (w_diff < -DEAD_BAND);
    assign w_below_cold = (r_var < r_cold);
    assign w_below_hot  = (r_var < r_hot);
    assign w_ramp       = w_act && w_below_cold && !w_below_hot;

    // Ramp numerator: (255 - base) * (count - hot)
    assign w_span = r_var - r_hot;
    assign w_gain = DRIVE_FULL - r_base;
    assign w_num  = {{TEMP_W{1'b0}}, w_gain} * {{DRIVE_W{1'b0}}, w_span};

    // Restoring division trial subtract
    assign w_trial = {1'b0, r_rem, r_quo[NUM_W-1]} - {2'b00, r_den};

    // Ramp target with step limit against the previous command
    assign w_target  = $signed({2'b00, DRIVE_FULL}) - $signed({2'b00, r_quo[DRIVE_W-1:0]});
    assign w_cmd_eff = (r_cmd == '0) ? $signed({2'b00, r_base}) : $signed({2'b00, r_cmd});
    assign w_step    = w_target - w_cmd_eff;
    assign w_up      = (w_step > STEP_LIMIT);
    assign w_dn      = (w_step < -STEP_LIMIT);

    always_comb begin
        w_ref_upd = 1'b1;
        if (!w_below_cold) begin
            w_next = '0;
        end else if (w_below_hot) begin
            w_next = $signed({2'b00, DRIVE_FULL});
        end else if (w_up) begin
            w_next    = w_cmd_eff + STEP_LIMIT;
            w_ref_upd = 1'b0;
        end else if (w_dn) begin
            w_next    = w_cmd_eff - STEP_LIMIT;
            w_ref_upd = 1'b0;
        end else begin
            w_next = w_target;
        end
    end

    // Clamp to the drive range
    always_comb begin
        if (w_next > $signed({2'b00, DRIVE_FULL})) begin
            w_clamped = DRIVE_FULL;
        end else if (w_next < 10'sd0) begin
            w_clamped = '0;
        end else begin
            w_clamped = w_next[DRIVE_W-1:0];
        end
    end

    assign w_out_free   = !r_out_valid || !i_stall;
    assign o_sts.ramp     = w_ramp;
    assign o_sts.out_free = w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hot  <= HOT_RESET;
            r_cold <= COLD_RESET;
            r_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HOT_COUNT:  r_hot  <= i_cfg_data;
                REG_COLD_COUNT: r_cold <= i_cfg_data;
                REG_BASE_DRIVE: r_base <= i_cfg_data[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // Controller state: reference, last command, last written drive
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref     <= REF_RESET;
            r_cmd     <= '0;
            r_written <= '0;
        end else if (i_cmd.commit && w_act) begin
            r_cmd     <= w_clamped;
            r_written <= w_clamped;
            if (w_ref_upd) begin
                r_ref <= $signed({1'b0, r_var});
            end
        end
    end

    // Sample capture, numerator load and division steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_var <= i_temp_count;
        end
        if (i_cmd.mul) begin
            r_quo <= w_num;
            r_rem <= '0;
            r_den <= r_cold - r_hot;
        end else if (i_cmd.div_step) begin
            if (!w_trial[TEMP_W+1]) begin
                r_rem <= w_trial[TEMP_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[TEMP_W-2:0], r_quo[NUM_W-1]};
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Output register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_drive   <= w_act ? w_clamped : r_written;
            r_out_changed <= w_act && (w_clamped != r_written);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive         = r_out_drive;
    assign o_drive_changed = r_out_changed;

    `FDC_ASSERT_SAME(a_quo_fits, i_cmd.commit && w_ramp, r_quo[NUM_W-1:DRIVE_W] == '0)
    `FDC_ASSERT_SAME(a_rem_below_den, i_cmd.commit && w_ramp, r_rem < r_den)
    `FDC_ASSERT_NEXT(a_out_hold, r_out_valid && i_stall, r_out_valid && $stable(r_out_drive) && $stable(r_out_changed))

endmodule

[rtl/fan_drive_controller.sv]
// Top level of the fan drive controller: controller, datapath and port wiring
// One temp_count beat in gives one drive beat out. A beat is taken only while the
// sequencer is idle; for a sample inside the dead band or off the ramp the result beat
// is presented from ST_FIN straight after ST_EVAL, for a sample on the ramp after the
// 24-step restoring divider that forms (255 - base) * (count - hot) / (cold - hot)
// one quotient bit per cycle. The next sample can be taken once the result is
// registered; registering waits while an earlier result still sits in the output
// register and the receiver stalls. A new sample can be accepted while the previous
// result still waits there; configuration writes are always ready and must only be
// issued while no sample is in flight.

module fan_drive_controller import fdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [TEMP_W-1:0]    i_temp_count,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DRIVE_W-1:0]   o_drive,
    output logic                 o_drive_changed,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TEMP_W-1:0]    i_cfg_data
);

    t_fdc_cmd w_cmd;
    t_fdc_sts w_sts;

    assign o_cfg_ready = 1'b1;

    fdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fdc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_temp_count    (i_temp_count),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive         (o_drive),
        .o_drive_changed (o_drive_changed)
    );

endmodule

[sim/fdc_checker.sv]
// Checker for the fan drive controller: drive predictor and result comparison
`timescale 1ns / 1ps

module fdc_checker import fdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [TEMP_W-1:0]    i_temp_count,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [DRIVE_W-1:0]   i_drive,
    input  logic                 i_drive_changed,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TEMP_W-1:0]    i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int FULL_DRIVE = DRIVE_FULL;
    localparam int MAX_STEP   = STEP_LIMIT;
    localparam int BAND       = DEAD_BAND;
    localparam int REF_INIT   = REF_RESET;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               changed;
    } t_drive_beat;

    // Shadow configuration and controller state
    logic [TEMP_W-1:0]  hot_lim;
    logic [TEMP_W-1:0]  cold_lim;
    logic [DRIVE_W-1:0] base_lvl;
    int                 ref_cnt;
    int                 cmd_drive;
    int                 fan_drive;

    t_drive_beat expected_drives[$];
    t_drive_beat got_beat;
    t_drive_beat want_beat;

    // Work out the drive beat for one sample and advance the shadow state
    function automatic t_drive_beat predict_drive(input logic [TEMP_W-1:0] count);
        int          sample;
        int          delta;
        int          next;
        int          hot;
        int          cold;
        int          base;
        int unsigned num;
        int unsigned den;
        t_drive_beat beat;
        sample = count;
        delta = sample - ref_cnt;
        beat.changed = 1'b0;
        if (delta > BAND || delta < -BAND) begin
            hot = hot_lim;
            cold = cold_lim;
            base = base_lvl;
            if (sample < cold) begin
                if (sample < hot) begin
                    ref_cnt = sample;
                    next = FULL_DRIVE;
                end else begin
                    // Ramp from full drive at the hot limit down to base at the cold limit
                    num = (FULL_DRIVE - base) * (sample - hot);
                    den = cold - hot;
                    next = FULL_DRIVE - int'(num / den);
                    if (cmd_drive == 0)
                        cmd_drive = base;
                    if (next - cmd_drive > MAX_STEP)
                        next = cmd_drive + MAX_STEP;
                    else if (next - cmd_drive < -MAX_STEP)
                        next = cmd_drive - MAX_STEP;
                    else
                        ref_cnt = sample;
                end
            end else begin
                ref_cnt = sample;
                next = 0;
            end
            if (next > FULL_DRIVE)
                next = FULL_DRIVE;
            else if (next < 0)
                next = 0;
            if (next != fan_drive) begin
                fan_drive = next;
                beat.changed = 1'b1;
            end
            cmd_drive = next;
        end
        beat.drive = fan_drive[DRIVE_W-1:0];
        return beat;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hot_lim = HOT_RESET;
            cold_lim = COLD_RESET;
            base_lvl = BASE_RESET;
            ref_cnt = REF_INIT;
            cmd_drive = 0;
            fan_drive = 0;
            expected_drives.delete();
            o_errors = 0;
        end else begin
            // Compare the result beat with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got_beat.drive = i_drive;
                got_beat.changed = i_drive_changed;
                if (expected_drives.size() == 0) begin
                    $display("%0t: unexpected result beat, drive %0d changed %0b",
                             $time, got_beat.drive, got_beat.changed);
                    o_errors++;
                end else begin
                    want_beat = expected_drives.pop_front();
                    if (got_beat.drive !== want_beat.drive) begin
                        $display("%0t: drive expected %0d actual %0d",
                                 $time, want_beat.drive, got_beat.drive);
                        o_errors++;
                    end
                    if (got_beat.changed !== want_beat.changed) begin
                        $display("%0t: drive_changed expected %0b actual %0b",
                                 $time, want_beat.changed, got_beat.changed);
                        o_errors++;
                    end
                end
            end
            // Predict on each accepted sample
            if (i_in_valid && !i_in_stall)
                expected_drives.push_back(predict_drive(i_temp_count));
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_HOT_COUNT:  hot_lim = i_cfg_data;
                    REG_COLD_COUNT: cold_lim = i_cfg_data;
                    REG_BASE_DRIVE: base_lvl = i_cfg_data[DRIVE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_drives.size();
    end

endmodule

[sim/tb.sv]
// Testbench top for the fan drive controller: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import fdc_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int PHASE_SAMPLES  = 120;
    localparam int NUM_PHASES     = 8;
    localparam int SETTLE_CYCLES  = 40;

    typedef enum int {RX_OPEN, RX_COIN, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [TEMP_W-1:0]    i_temp_count;
    logic                 o_valid;
    logic                 i_stall;
    logic [DRIVE_W-1:0]   o_drive;
    logic                 o_drive_changed;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TEMP_W-1:0]    i_cfg_data;

    int errors;
    int pending;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int cur_hot = HOT_RESET;
    int cur_cold = COLD_RESET;
    int last_count = 0;

    fan_drive_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_temp_count    (i_temp_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive         (o_drive),
        .o_drive_changed (o_drive_changed),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    fdc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_temp_count    (i_temp_count),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_drive         (o_drive),
        .i_drive_changed (o_drive_changed),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: switch at random between stall patterns
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 150);
        end
        stall_left--;
        case (rx_mode)
            RX_OPEN:     i_stall <= 1'b0;
            RX_COIN:     i_stall <= ($urandom_range(0, 1) == 1);
            RX_HEAVY:    i_stall <= ($urandom_range(0, 7) != 0);
            RX_PERIODIC: i_stall <= ((stall_left % 16) < 5);
            default:     i_stall <= 1'b0;
        endcase
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Present one sample and hold it until the block takes it
    task automatic send_count(input logic [TEMP_W-1:0] count);
        i_valid <= 1'b1;
        i_temp_count <= count;
        last_count = count;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result beat is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Send with bursts, random gaps and an occasional full drain
    task automatic paced_send(input logic [TEMP_W-1:0] count);
        send_count(count);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 29) == 0) begin
                drain();
            end else begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Reprogram all limits once the block has gone idle
    task automatic set_limits(input int hot, input int cold, input int base);
        drain();
        cfg_write(REG_HOT_COUNT, 16'(hot));
        cfg_write(REG_COLD_COUNT, 16'(cold));
        cfg_write(REG_BASE_DRIVE, {8'($urandom), 8'(base)});
        i_cfg_valid <= 1'b0;
        cur_hot = hot;
        cur_cold = cold;
    endtask

    // Bias samples toward the ramp and the dead band around the last sample
    function automatic logic [TEMP_W-1:0] pick_count();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (cur_hot < cur_cold && r < 45)
            v = $urandom_range(cur_cold - 1, cur_hot);
        else if (r < 62)
            v = last_count + $urandom_range(0, 24) - 12;
        else if (r < 72)
            v = (cur_hot > 0) ? $urandom_range(0, cur_hot - 1) : 0;
        else if (r < 84)
            v = $urandom_range(cur_cold, 65535);
        else
            v = $urandom_range(0, 65535);
        if (v < 0)
            v = 0;
        else if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    int directed_counts[] = '{0, 65535, 65531, 65530, 100, 100, 100, 100, 100, 0, 3, 10,
                              199, 200, 196, 195, 49, 50, 150, 32768, 4};
    int phase_hot[]  = '{50, 0, 0, 1000, 3000, 65534};
    int phase_cold[] = '{200, 65535, 65535, 1000, 500, 65535};
    int phase_base[] = '{64, 0, 255, 128, 10, 200};

    initial begin
        int hot;
        int cold;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_temp_count = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_HOT_COUNT;
        i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed samples under the reset limits
        foreach (directed_counts[k])
            paced_send(16'(directed_counts[k]));

        // Random samples over a sweep of limit settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < phase_hot.size()) begin
                set_limits(phase_hot[p], phase_cold[p], phase_base[p]);
            end else begin
                hot = $urandom_range(0, 2000);
                cold = hot + $urandom_range(1, 3000);
                set_limits(hot, cold, $urandom_range(0, 255));
            end
            repeat (PHASE_SAMPLES)
                paced_send(pick_count());
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
